// File: rtl/awqd_pkg.sv
// shared constants and types for the alpha-weighted quad downsampler
`default_nettype none

package awqd_pkg;

	localparam int CH_W            = 8;
	localparam int PIX_W           = 32;
	localparam int NUM_PIX         = 4;
	localparam int NUM_COL         = 3;
	localparam int ASUM_W          = 10;
	localparam int PROD_W          = 16;
	localparam int WSUM_W          = 18;
	localparam int DIV_STAGES      = 4;
	localparam int QBITS_PER_STAGE = CH_W / DIV_STAGES;
	localparam int PIPE_STAGES     = 2 + DIV_STAGES;
	localparam int IN_W            = NUM_PIX * PIX_W;

	localparam logic [CH_W-1:0] CHAN_MAX = 8'hFF;

	typedef logic [CH_W-1:0]   chan_t;
	typedef logic [ASUM_W-1:0] asum_t;
	typedef logic [PROD_W-1:0] prod_t;
	typedef logic [WSUM_W-1:0] wsum_t;

	typedef struct packed {
		logic  zero;
		chan_t alpha;
	} tag_t;

endpackage

`default_nettype wire

// File: rtl/alpha_weighted_quad_downsample.sv
// Alpha-weighted 2x2 box downsampler for RGBA8888 quads. One quad enters per
// beat and one pixel leaves per beat; the block takes a new quad every cycle
// unless an output stall has filled the pipeline, and each quad passes through
// a multiply stage, an add stage and four divider stages, each resolving two
// quotient bits of the three colour means. A stall on the output holds only the
// stages that are full, so bubbles ahead of it still fill. Colours are
// floor(sum(c*a)/sum(a)); alpha is 255 for a pure cutout quad and (sum(a)+2)/4
// otherwise; a quad with all alphas zero gives an all-zero pixel.
`default_nettype none

module alpha_weighted_quad_downsample (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        s_tvalid,
	output logic                             s_tready,
	// pixel_top_left, pixel_top_right, pixel_bottom_left, pixel_bottom_right
	input  wire logic [awqd_pkg::IN_W-1:0]   s_tdata,
	output logic                             m_tvalid,
	input  wire logic                        m_tready,
	// out_pixel
	output logic [awqd_pkg::PIX_W-1:0]       m_tdata
);
	import awqd_pkg::*;

	logic [PIPE_STAGES-1:0] valid_s;
	logic [PIPE_STAGES-1:0] valid_in;
	logic [PIPE_STAGES-1:0] en;

	prod_t               prod_d  [NUM_PIX][NUM_COL];
	asum_t               asum_d;
	logic                cutout_d;
	prod_t               prod_s1 [NUM_PIX][NUM_COL];
	asum_t               asum_s1;
	logic                cutout_s1;

	wsum_t [NUM_COL-1:0] wsum_d;
	tag_t                tag_d;
	wsum_t [NUM_COL-1:0] wsum_s2;
	asum_t               asum_s2;
	tag_t                tag_s2;

	chan_t [NUM_COL-1:0] quo;
	tag_t                tag_out;
	logic [ASUM_W:0]     asum_rnd;

	// stall chain
	always_comb begin
		en[PIPE_STAGES-1] = !valid_s[PIPE_STAGES-1] || m_tready;
		for (int k = PIPE_STAGES - 2; k >= 0; k--) begin
			en[k] = !valid_s[k] || en[k+1];
		end
		valid_in = {valid_s[PIPE_STAGES-2:0], s_tvalid};
	end

	assign s_tready = en[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= '0;
		end else begin
			for (int k = 0; k < PIPE_STAGES; k++) begin
				if (en[k]) begin
					valid_s[k] <= valid_in[k];
				end
			end
		end
	end

	// products and alpha sum
	always_comb begin
		chan_t a;
		asum_d   = '0;
		cutout_d = 1'b1;
		for (int i = 0; i < NUM_PIX; i++) begin
			a        = s_tdata[i*PIX_W + 3*CH_W +: CH_W];
			asum_d   = asum_d + ASUM_W'(a);
			cutout_d = cutout_d & ((a == '0) || (a == CHAN_MAX));
			for (int c = 0; c < NUM_COL; c++) begin
				prod_d[i][c] = prod_t'(s_tdata[i*PIX_W + c*CH_W +: CH_W]) * prod_t'(a);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			prod_s1   <= prod_d;
			asum_s1   <= asum_d;
			cutout_s1 <= cutout_d;
		end
	end

	// weighted sums and output alpha
	always_comb begin
		for (int c = 0; c < NUM_COL; c++) begin
			wsum_d[c] = '0;
			for (int i = 0; i < NUM_PIX; i++) begin
				wsum_d[c] = wsum_d[c] + WSUM_W'(prod_s1[i][c]);
			end
		end
		asum_rnd   = {1'b0, asum_s1} + (ASUM_W+1)'(2);
		tag_d.zero = (asum_s1 == '0);
		if (tag_d.zero) begin
			tag_d.alpha = '0;
		end else if (cutout_s1) begin
			tag_d.alpha = CHAN_MAX;
		end else begin
			tag_d.alpha = asum_rnd[CH_W+1:2];
		end
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			wsum_s2 <= wsum_d;
			asum_s2 <= asum_s1;
			tag_s2  <= tag_d;
		end
	end

	awqd_divider u_div (
		.clk     (clk),
		.en      (en[PIPE_STAGES-1:2]),
		.num     (wsum_s2),
		.den     (asum_s2),
		.tag_in  (tag_s2),
		.quo     (quo),
		.tag_out (tag_out)
	);

	assign m_tvalid = valid_s[PIPE_STAGES-1];
	assign m_tdata  = tag_out.zero ? '0 : {tag_out.alpha, quo[2], quo[1], quo[0]};

	a_accept_fills: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> valid_s[0])
		else $error("accepted beat did not reach stage one");

	a_bubble_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s[0] |-> s_tready)
		else $error("empty first stage refused a beat");

	a_drain_moves: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && valid_s[PIPE_STAGES-2] |=> m_tvalid)
		else $error("pipeline lost a beat on drain");

	a_zero_pixel: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && tag_out.zero |-> m_tdata == '0)
		else $error("transparent quad gave a nonzero pixel");

endmodule

`default_nettype wire

// File: rtl/awqd_divider.sv
// pipelined restoring divider for the three weighted colour sums
`default_nettype none

module awqd_divider (
	input  wire logic                                   clk,
	input  wire logic [awqd_pkg::DIV_STAGES-1:0]        en,
	input  wire awqd_pkg::wsum_t [awqd_pkg::NUM_COL-1:0] num,
	input  wire awqd_pkg::asum_t                        den,
	input  wire awqd_pkg::tag_t                         tag_in,
	output awqd_pkg::chan_t [awqd_pkg::NUM_COL-1:0]     quo,
	output awqd_pkg::tag_t                              tag_out
);
	import awqd_pkg::*;

	wsum_t [NUM_COL-1:0] rem_s [DIV_STAGES-1];
	asum_t               den_s [DIV_STAGES-1];
	chan_t [NUM_COL-1:0] quo_s [DIV_STAGES];
	tag_t                tag_s [DIV_STAGES];

	wsum_t [NUM_COL-1:0] src_rem [DIV_STAGES];
	chan_t [NUM_COL-1:0] src_quo [DIV_STAGES];
	asum_t               src_den [DIV_STAGES];
	tag_t                src_tag [DIV_STAGES];
	wsum_t [NUM_COL-1:0] nxt_rem [DIV_STAGES];
	chan_t [NUM_COL-1:0] nxt_quo [DIV_STAGES];

	always_comb begin
		wsum_t r;
		wsum_t trial;
		chan_t qv;
		int    j;
		src_rem[0] = num;
		src_quo[0] = '0;
		src_den[0] = den;
		src_tag[0] = tag_in;
		for (int k = 1; k < DIV_STAGES; k++) begin
			src_rem[k] = rem_s[k-1];
			src_quo[k] = quo_s[k-1];
			src_den[k] = den_s[k-1];
			src_tag[k] = tag_s[k-1];
		end
		for (int k = 0; k < DIV_STAGES; k++) begin
			for (int c = 0; c < NUM_COL; c++) begin
				r  = src_rem[k][c];
				qv = src_quo[k][c];
				for (int b = 0; b < QBITS_PER_STAGE; b++) begin
					j     = CH_W - 1 - QBITS_PER_STAGE * k - b;
					trial = WSUM_W'(src_den[k]) << j;
					if (r >= trial) begin
						r     = r - trial;
						qv[j] = 1'b1;
					end
				end
				nxt_rem[k][c] = r;
				nxt_quo[k][c] = qv;
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < DIV_STAGES - 1; k++) begin
			if (en[k]) begin
				rem_s[k] <= nxt_rem[k];
				den_s[k] <= src_den[k];
			end
		end
		for (int k = 0; k < DIV_STAGES; k++) begin
			if (en[k]) begin
				quo_s[k] <= nxt_quo[k];
				tag_s[k] <= src_tag[k];
			end
		end
	end

	assign quo     = quo_s[DIV_STAGES-1];
	assign tag_out = tag_s[DIV_STAGES-1];

endmodule

`default_nettype wire
